// ----- rtl/setl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted entry table lookup package
// Shared types, status codes and constants for the sorted entry table.
// ----------------------------------------------------------------------------
package setl_pkg;

  localparam int unsigned MaxRowsDefault = 1024;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_ORDER     = 3'd3,
    ST_FULL      = 3'd4,
    ST_ERROR     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] REG_DATA_START    = 2'd0;
  localparam logic [1:0] REG_SOURCE_LENGTH = 2'd1;
  localparam logic [1:0] REG_WIDE_IDS      = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] entry_id;
    logic [31:0] language;
    logic [31:0] block_size;
    logic [31:0] start_block;
    logic [31:0] entry_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_offset;
    logic [31:0] found_length;
    logic [9:0]  row_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the input transaction
    logic mul_lo;    // first partial product stage
    logic mul_hi;    // combine partial products
    logic check;     // evaluate load checks
    logic store;     // append the row
    logic clear;     // reset count and error
    logic set_error; // set the sticky error
    logic search_init;
    logic probe;     // issue a memory read at mid
    logic compare;   // compare read data and narrow the range
    logic out_load;  // load the output register
    logic [2:0] out_status;
    logic out_data;  // use the row data, else zero
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic table_error;
    logic full;
    logic malformed;
    logic order_bad;
    logic narrow_miss;
    logic range_empty;
    logic hit;
  } stat_t;

endpackage

// ----- rtl/setl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted entry table datapath
// Row memories, offset multiplier, load checks and binary search range.
// ----------------------------------------------------------------------------
module setl_datapath #(
  parameter int unsigned MAX_ROWS = setl_pkg::MaxRowsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  setl_pkg::in_item_t    in_item,
  input  logic [31:0]           data_start,
  input  logic [63:0]           source_length,
  input  logic                  wide_ids,
  input  setl_pkg::cmd_t        cmd,
  output setl_pkg::stat_t       stat,
  output setl_pkg::out_item_t   out_item
);

  localparam int unsigned IW = $clog2(MAX_ROWS);
  localparam int unsigned CW = IW + 1;

  // Storage for the table rows.
  logic [63:0] mem_id  [MAX_ROWS];
  logic [15:0] mem_lang[MAX_ROWS];
  logic [63:0] mem_off [MAX_ROWS];
  logic [31:0] mem_len [MAX_ROWS];

  setl_pkg::in_item_t item;
  logic [CW-1:0] row_count;
  logic          table_error;
  logic [63:0]   last_id;
  logic [15:0]   last_lang;
  logic [31:0]   pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0]   offset;
  logic          malformed;
  logic          order_bad;
  logic [63:0]   key_id;
  logic [CW-1:0] lo, hi;
  logic [IW-1:0] mid;
  logic [63:0]   rd_id, rd_off;
  logic [15:0]   rd_lang;
  logic [31:0]   rd_len;
  logic          hit;
  logic [CW-1:0] mid_sum;

  assign mid_sum = lo + ((hi - lo) >> 1);

  // Input capture and key formation.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
      key_id <= wide_ids ? in_item.entry_id : {32'd0, in_item.entry_id[31:0]};
    end
  end

  // Offset multiplier: 16x16 partial products, then combination.
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      pp_ll <= item.block_size[15:0] * item.start_block[15:0];
      pp_lh <= item.block_size[15:0] * item.start_block[31:16];
      pp_hl <= item.block_size[31:16] * item.start_block[15:0];
      pp_hh <= item.block_size[31:16] * item.start_block[31:16];
    end
    if (cmd.mul_hi) begin
      offset <= {pp_hh, pp_ll} + ({32'd0, pp_lh} << 16) + ({32'd0, pp_hl} << 16);
    end
  end

  // Load checks, registered.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      malformed <= (item.block_size == 32'd0) || (offset < {32'd0, data_start}) ||
                   (offset > source_length) ||
                   ({32'd0, item.entry_length} > (source_length - offset)) ||
                   (item.language[31:16] != 16'd0);
      order_bad <= (row_count != '0) &&
                   !((last_id < key_id) ||
                     ((last_id == key_id) && (last_lang < item.language[15:0])));
    end
  end

  // Row memories: one write port, one registered read port at the new midpoint.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem_id[row_count[IW-1:0]]   <= key_id;
      mem_lang[row_count[IW-1:0]] <= item.language[15:0];
      mem_off[row_count[IW-1:0]]  <= offset;
      mem_len[row_count[IW-1:0]]  <= item.entry_length;
    end
    if (cmd.probe) begin
      rd_id   <= mem_id[mid_sum[IW-1:0]];
      rd_lang <= mem_lang[mid_sum[IW-1:0]];
      rd_off  <= mem_off[mid_sum[IW-1:0]];
      rd_len  <= mem_len[mid_sum[IW-1:0]];
    end
  end

  // Table count, sticky error and the last stored key.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      table_error <= 1'b0;
    end else begin
      if (cmd.clear) begin
        row_count   <= '0;
        table_error <= 1'b0;
      end
      if (cmd.set_error) table_error <= 1'b1;
      if (cmd.store) row_count <= row_count + 1'b1;
    end
    if (cmd.store) begin
      last_id   <= key_id;
      last_lang <= item.language[15:0];
    end
  end

  // Binary search range.
  assign hit = (rd_id == item.entry_id) && ({16'd0, rd_lang} == item.language);

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo <= '0;
      hi <= row_count;
    end
    if (cmd.probe) mid <= mid_sum[IW-1:0];
    if (cmd.compare && !hit) begin
      if ((rd_id < item.entry_id) ||
          ((rd_id == item.entry_id) && ({16'd0, rd_lang} < item.language))) begin
        lo <= {1'b0, mid} + 1'b1;
      end else begin
        hi <= {1'b0, mid};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.status <= cmd.out_status;
      if (cmd.out_data && cmd.compare) begin
        out_item.found_offset <= rd_off;
        out_item.found_length <= rd_len;
        out_item.row_index    <= 10'({1'b0, mid});
      end else if (cmd.out_data) begin
        out_item.found_offset <= offset;
        out_item.found_length <= item.entry_length;
        out_item.row_index    <= 10'(row_count);
      end else begin
        out_item.found_offset <= '0;
        out_item.found_length <= '0;
        out_item.row_index    <= '0;
      end
    end
  end

  assign stat.mode        = item.mode;
  assign stat.table_error = table_error;
  assign stat.full        = (row_count >= CW'(MAX_ROWS));
  assign stat.malformed   = malformed;
  assign stat.order_bad   = order_bad;
  assign stat.narrow_miss = !wide_ids && (item.entry_id[63:32] != 32'd0);
  assign stat.range_empty = !(lo < hi);
  assign stat.hit         = hit;

endmodule

// ----- rtl/setl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted entry table controller
// Sequences loads, lookups and clears and holds the output handshake.
// ----------------------------------------------------------------------------
module setl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  setl_pkg::stat_t stat,
  output setl_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_CHECK, S_DECIDE, S_PROBE, S_COMPARE
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   done;

  // Free to accept only when idle; a held result is waited for at decode.
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!(out_valid && out_stall)) begin
          case (stat.mode)
            setl_pkg::MODE_LOAD: begin
              if (stat.table_error) begin
                cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_ERROR; done = 1'b1;
              end else if (stat.full) begin
                cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_FULL;
                cmd.set_error = 1'b1; done = 1'b1;
              end else begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL;
              end
            end
            setl_pkg::MODE_LOOKUP: begin
              if (stat.table_error) begin
                cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_ERROR; done = 1'b1;
              end else if (stat.narrow_miss) begin
                cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_NOT_FOUND; done = 1'b1;
              end else begin
                cmd.search_init = 1'b1;
                state_next = S_PROBE;
              end
            end
            setl_pkg::MODE_CLEAR: begin
              cmd.clear = 1'b1; cmd.out_load = 1'b1;
              cmd.out_status = setl_pkg::ST_OK; done = 1'b1;
            end
            default: begin
              cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_OK; done = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_hi = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.out_load = 1'b1;
        done = 1'b1;
        if (stat.malformed) begin
          cmd.out_status = setl_pkg::ST_MALFORMED; cmd.set_error = 1'b1;
        end else if (stat.order_bad) begin
          cmd.out_status = setl_pkg::ST_ORDER; cmd.set_error = 1'b1;
        end else begin
          cmd.out_status = setl_pkg::ST_OK; cmd.out_data = 1'b1; cmd.store = 1'b1;
        end
      end
      S_PROBE: begin
        // The midpoint row is read at the end of this cycle.
        if (stat.range_empty) begin
          cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_NOT_FOUND; done = 1'b1;
        end else begin
          cmd.probe  = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        if (stat.hit) begin
          cmd.out_load = 1'b1; cmd.out_status = setl_pkg::ST_OK;
          cmd.out_data = 1'b1; done = 1'b1;
        end else begin
          state_next = S_PROBE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (done) state_next = S_IDLE;
    out_valid_next = done ? 1'b1 : (out_valid && out_stall);
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/sorted_entry_table_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted entry table lookup
// Loads a sorted entry table row by row and finds rows by binary search.
// ----------------------------------------------------------------------------
//  Channel   Signals                                 Direction
//  cfg       cfg_valid cfg_ready cfg_index cfg_data  in   register writes
//  in        in_valid in_stall in_data               in   load, lookup, clear
//  out       out_valid out_stall out_data            out  one result each
//
// A load steps through decode and partial products, combine, check and store.
// A lookup reads the row memory read port and compares, once per probe, for up to
// floor(log2(MAX_ROWS))+1 probes. A clear completes at its decode step.
// Reset is synchronous; it empties the table and clears the error.
// A held result stalls a new transaction only at its decode step.
// ----------------------------------------------------------------------------
module sorted_entry_table_lookup #(
  parameter int unsigned MAX_ROWS = setl_pkg::MaxRowsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  setl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output setl_pkg::out_item_t out_data
);

  logic [31:0]     data_start;
  logic [63:0]     source_length;
  logic            wide_ids;
  setl_pkg::cmd_t  cmd;
  setl_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_start    <= 32'd8;
      source_length <= '0;
      wide_ids      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        setl_pkg::REG_DATA_START:    data_start    <= cfg_data[31:0];
        setl_pkg::REG_SOURCE_LENGTH: source_length <= cfg_data;
        setl_pkg::REG_WIDE_IDS:      wide_ids      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  setl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  setl_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk, .rst, .in_item(in_data), .data_start, .source_length, .wide_ids,
    .cmd, .stat, .out_item(out_data)
  );

endmodule
